// ===== sv/acd_pkg.sv =====
// Shared types and constants for the AVI chunk demultiplexer.
`default_nettype none

package acd_pkg;

  // Field widths
  localparam int unsigned ByteW      = 8;
  localparam int unsigned MaxChunkW  = 24;
  localparam int unsigned FrameSizeW = 20;
  localparam int unsigned CfgDataW   = 24;
  localparam int unsigned InDataW    = 16;  // byte, skip, playing, zero fill
  localparam int unsigned OutDataW   = 32;  // payload, frame size, zero fill

  // Register reset values
  localparam logic [MaxChunkW-1:0]  MaxChunkReset = 24'd1000000;
  localparam logic [FrameSizeW-1:0] CapacityReset = 20'd65536;

  // Register indexes
  typedef enum logic {
    CFG_MAX_CHUNK  = 1'b0,
    CFG_FRAME_CAP  = 1'b1
  } cfg_idx_e;

  // Chunk id characters
  localparam logic [ByteW-1:0] ChD = 8'h64;  // 'd'
  localparam logic [ByteW-1:0] ChC = 8'h63;  // 'c'
  localparam logic [ByteW-1:0] ChW = 8'h77;  // 'w'
  localparam logic [ByteW-1:0] ChB = 8'h62;  // 'b'

  // Result event codes
  typedef enum logic [2:0] {
    EV_VIDEO = 3'd0,
    EV_AUDIO = 3'd1,
    EV_SKIP  = 3'd2,
    EV_EMPTY = 3'd3,
    EV_BAD   = 3'd4
  } event_e;

  // One result beat
  typedef struct packed {
    event_e                ev;
    logic [ByteW-1:0]      payload;
    logic                  frame_end;
    logic [FrameSizeW-1:0] frame_size;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/acd_parser.sv =====
// Chunk header parser and payload router: state registers plus one beat of decode.
`default_nettype none

module acd_parser (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // configuration writes
  input  wire logic                      cfg_we_i,
  input  wire acd_pkg::cfg_idx_e         cfg_idx_i,
  input  wire logic [acd_pkg::CfgDataW-1:0] cfg_data_i,
  // accepted input beat
  input  wire logic                      accept_i,
  input  wire logic [acd_pkg::ByteW-1:0] byte_i,
  input  wire logic                      skip_i,
  input  wire logic                      play_i,
  // result of this beat
  output logic                           res_valid_o,
  output acd_pkg::result_t               res_o
);
  import acd_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_VIDEO,
    PH_AUDIO,
    PH_DROP,
    PH_PAD,
    PH_HALT
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [2:0]            hidx_q, hidx_d;
  logic [ByteW-1:0]      type_hi_q, type_hi_d;
  logic [ByteW-1:0]      type_lo_q, type_lo_d;
  logic [MaxChunkW-1:0]  len_q, len_d;
  logic [MaxChunkW-1:0]  left_q, left_d;
  logic                  pad_q, pad_d;
  logic [MaxChunkW-1:0]  max_q;
  logic [FrameSizeW-1:0] cap_q;

  logic [MaxChunkW-1:0]  left_dec;
  logic                  bad_len;
  logic                  over_cap;
  logic                  is_video;
  logic                  is_audio;
  phase_e                done_phase;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxChunkReset;
      cap_q <= CapacityReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_CHUNK: max_q <= cfg_data_i;
        CFG_FRAME_CAP: cap_q <= cfg_data_i[FrameSizeW-1:0];
        default:       max_q <= max_q;
      endcase
    end
  end

  // Header decode helpers; top length byte arrives on the last header beat
  assign bad_len    = (byte_i != '0) || (len_q > max_q);
  assign over_cap   = len_q > {{(MaxChunkW-FrameSizeW){1'b0}}, cap_q};
  assign is_video   = (type_hi_q == ChD) && (type_lo_q == ChC);
  assign is_audio   = (type_hi_q == ChW) && (type_lo_q == ChB);
  assign left_dec   = left_q - MaxChunkW'(1);
  assign done_phase = pad_q ? PH_PAD : PH_HEADER;

  // Next state and result of the current beat
  always_comb begin
    phase_d     = phase_q;
    hidx_d      = hidx_q;
    type_hi_d   = type_hi_q;
    type_lo_d   = type_lo_q;
    len_d       = len_q;
    left_d      = left_q;
    pad_d       = pad_q;
    res_valid_o = 1'b0;
    res_o       = '{ev: EV_VIDEO, payload: '0, frame_end: 1'b0, frame_size: '0};

    unique case (phase_q)
      PH_HEADER: begin
        hidx_d = hidx_q + 3'd1;
        unique case (hidx_q)
          3'd0: begin
            type_hi_d = '0;
            type_lo_d = '0;
            len_d     = '0;
          end
          3'd1: ;
          3'd2: type_hi_d = byte_i;
          3'd3: type_lo_d = byte_i;
          3'd4: len_d[7:0]   = byte_i;
          3'd5: len_d[15:8]  = byte_i;
          3'd6: len_d[23:16] = byte_i;
          default: begin
            // last header byte: check, then route
            hidx_d = 3'd0;
            pad_d  = len_q[0];
            left_d = len_q;
            if (bad_len) begin
              phase_d     = PH_HALT;
              res_valid_o = 1'b1;
              res_o.ev    = EV_BAD;
            end else if (is_video) begin
              if (skip_i) begin
                phase_d     = (len_q == '0) ? PH_HEADER : PH_DROP;
                res_valid_o = 1'b1;
                res_o.ev    = EV_SKIP;
              end else if (over_cap) begin
                phase_d = PH_DROP;
              end else if (len_q == '0) begin
                phase_d     = PH_HEADER;
                res_valid_o = 1'b1;
                res_o.ev    = EV_EMPTY;
              end else begin
                phase_d = PH_VIDEO;
              end
            end else if (is_audio) begin
              phase_d = (len_q == '0) ? PH_HEADER : PH_AUDIO;
            end else begin
              phase_d = (len_q == '0) ? PH_HEADER : PH_DROP;
            end
          end
        endcase
      end

      PH_VIDEO: begin
        left_d        = left_dec;
        res_valid_o   = 1'b1;
        res_o.ev      = EV_VIDEO;
        res_o.payload = byte_i;
        if (left_dec == '0) begin
          phase_d          = done_phase;
          hidx_d           = 3'd0;
          res_o.frame_end  = 1'b1;
          res_o.frame_size = len_q[FrameSizeW-1:0];
        end
      end

      PH_AUDIO: begin
        left_d = left_dec;
        if (left_dec == '0) begin
          phase_d = done_phase;
          hidx_d  = 3'd0;
        end
        if (play_i) begin
          res_valid_o   = 1'b1;
          res_o.ev      = EV_AUDIO;
          res_o.payload = byte_i;
        end
      end

      PH_DROP: begin
        left_d = left_dec;
        if (left_dec == '0) begin
          phase_d = done_phase;
          hidx_d  = 3'd0;
        end
      end

      PH_PAD: begin
        pad_d   = 1'b0;
        hidx_d  = 3'd0;
        phase_d = PH_HEADER;
      end

      default: ;  // halted until reset
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      hidx_q    <= 3'd0;
      type_hi_q <= '0;
      type_lo_q <= '0;
      len_q     <= '0;
      left_q    <= '0;
      pad_q     <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      hidx_q    <= hidx_d;
      type_hi_q <= type_hi_d;
      type_lo_q <= type_lo_d;
      len_q     <= len_d;
      left_q    <= left_d;
      pad_q     <= pad_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/acd_out_buf.sv =====
// Two-entry result buffer: output register plus skid entry.
`default_nettype none

module acd_out_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire acd_pkg::result_t data_i,
  output logic                  room_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output acd_pkg::result_t      data_o
);
  import acd_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  result_t    head_q;
  result_t    tail_q;
  logic       pop;

  assign valid_o = cnt_q != 2'd0;
  assign room_o  = cnt_q != 2'd2;
  assign data_o  = head_q;
  assign pop     = valid_o && ready_i;

  // Occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Entries: head feeds the port, tail catches a beat while head is stalled
  always_ff @(posedge clk_i) begin
    if (push_i && !pop) begin
      if (cnt_q == 2'd0) begin
        head_q <= data_i;
      end else begin
        tail_q <= data_i;
      end
    end else if (pop && !push_i) begin
      head_q <= tail_q;
    end else if (pop && push_i) begin
      if (cnt_q == 2'd1) begin
        head_q <= data_i;
      end else begin
        head_q <= tail_q;
        tail_q <= data_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/avi_chunk_demux_top.sv =====
// Top level of the AVI movi-list chunk demultiplexer.
//
//  Channel   Dir  Handshake                    Contents
//  s_axis    in   s_axis_tvalid/s_axis_tready  one stream byte plus skip and playing flags
//  m_axis    out  m_axis_tvalid/m_axis_tready  event in tuser, byte and frame size in tdata
//  cfg       in   cfg_we_i                     register write, no handshake back
//
// One byte per clock cycle while the output buffer has room: the parser decodes a beat in
// the cycle it is accepted, and the result is registered into the output buffer.
// A two-entry output buffer keeps input flowing while one result waits;
// input stalls only when both entries are full.
// Reset is asynchronous and clears the parser state and the buffer occupancy.
// After a bad chunk size the block keeps taking bytes but gives no results until reset.
`default_nettype none

module avi_chunk_demux_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration
  input  wire logic                        cfg_we_i,
  input  wire acd_pkg::cfg_idx_e           cfg_idx_i,
  input  wire logic [acd_pkg::CfgDataW-1:0] cfg_data_i,
  // input stream
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] stream_byte, [8] skip_video, [9] playing, [15:10] zero
  input  wire logic [acd_pkg::InDataW-1:0] s_axis_tdata,
  // output stream
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [7:0] payload, [27:8] frame_size, [31:28] zero
  output logic [acd_pkg::OutDataW-1:0]     m_axis_tdata,
  // [2:0] event_res
  output logic [2:0]                       m_axis_tuser,
  // frame_end
  output logic                             m_axis_tlast
);
  import acd_pkg::*;

  logic    accept;
  logic    room;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  acd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata[ByteW-1:0]),
    .skip_i      (s_axis_tdata[ByteW]),
    .play_i      (s_axis_tdata[ByteW+1]),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  acd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && res_valid),
    .data_i  (res),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_res)
  );

  // Output beat packing
  assign m_axis_tdata = {{(OutDataW-ByteW-FrameSizeW){1'b0}}, out_res.frame_size,
                         out_res.payload};
  assign m_axis_tuser = out_res.ev;
  assign m_axis_tlast = out_res.frame_end;

endmodule

`default_nettype wire

// ===== dv/avi_chunk_demux_checker.sv =====
// Scoreboard for the AVI chunk demultiplexer: predicts each result beat and compares it.
`timescale 1ns / 100ps

module avi_chunk_demux_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  acd_pkg::cfg_idx_e             cfg_idx_i,
  input  logic [acd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [acd_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [acd_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic [2:0]                    m_axis_tuser,
  input  logic                          m_axis_tlast,
  output int                            fail_count,
  output int                            results_due,
  output int                            beat_count,
  output int                            result_count,
  output int                            frame_count,
  output int                            halt_count
);
  import acd_pkg::*;

  // Parser position within the chunk stream
  typedef enum logic [2:0] {
    PARSE_HDR,
    PARSE_VIDEO,
    PARSE_AUDIO,
    PARSE_DROP,
    PARSE_PAD,
    PARSE_HALT
  } parse_e;

  // Register copies
  logic [MaxChunkW-1:0]  max_chunk;
  logic [FrameSizeW-1:0] frame_cap;

  // Parser state
  parse_e      parse;
  logic [2:0]  hdr_idx;
  logic [15:0] id_bytes;
  logic [31:0] chunk_len;
  logic [31:0] bytes_left;
  logic        pad_due;

  result_t due_q[$];
  result_t next_res;
  result_t want;

  function automatic result_t make_res(event_e ev, logic [7:0] b, logic last,
                                       logic [FrameSizeW-1:0] size);
    result_t r;
    r.ev         = ev;
    r.payload    = b;
    r.frame_end  = last;
    r.frame_size = size;
    return r;
  endfunction

  function automatic void end_payload();
    hdr_idx = 3'd0;
    parse   = pad_due ? PARSE_PAD : PARSE_HDR;
  endfunction

  function automatic void begin_payload(parse_e ph);
    bytes_left = chunk_len;
    if (bytes_left == 32'd0) end_payload();
    else parse = ph;
  endfunction

  // Advance the parser by one stream byte; returns 1 when a result beat is due
  function automatic logic demux_step(input logic [7:0] b, input logic skip,
                                      input logic play, output result_t r);
    r = '0;
    case (parse)
      PARSE_HDR: begin
        if (hdr_idx == 3'd0) begin
          id_bytes  = '0;
          chunk_len = '0;
        end
        if (hdr_idx == 3'd2) id_bytes[15:8] = b;
        else if (hdr_idx == 3'd3) id_bytes[7:0] = b;
        else if (hdr_idx >= 3'd4) chunk_len[8*(hdr_idx-3'd4) +: 8] = b;
        if (hdr_idx != 3'd7) begin
          hdr_idx = hdr_idx + 3'd1;
          return 1'b0;
        end
        // last header byte: size check first, then route
        hdr_idx = 3'd0;
        pad_due = chunk_len[0];
        if (chunk_len > {8'd0, max_chunk}) begin
          parse = PARSE_HALT;
          r = make_res(EV_BAD, 8'd0, 1'b0, '0);
          return 1'b1;
        end
        if (id_bytes == {ChD, ChC}) begin
          if (skip) begin
            begin_payload(PARSE_DROP);
            r = make_res(EV_SKIP, 8'd0, 1'b0, '0);
            return 1'b1;
          end
          if (chunk_len > {12'd0, frame_cap}) begin
            begin_payload(PARSE_DROP);
            return 1'b0;
          end
          if (chunk_len == 32'd0) begin
            end_payload();
            r = make_res(EV_EMPTY, 8'd0, 1'b0, '0);
            return 1'b1;
          end
          begin_payload(PARSE_VIDEO);
          return 1'b0;
        end
        if (id_bytes == {ChW, ChB}) begin
          begin_payload(PARSE_AUDIO);
          return 1'b0;
        end
        begin_payload(PARSE_DROP);
        return 1'b0;
      end
      PARSE_VIDEO: begin
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == 32'd0) begin
          end_payload();
          r = make_res(EV_VIDEO, b, 1'b1, chunk_len[FrameSizeW-1:0]);
        end else begin
          r = make_res(EV_VIDEO, b, 1'b0, '0);
        end
        return 1'b1;
      end
      PARSE_AUDIO: begin
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == 32'd0) end_payload();
        if (play) r = make_res(EV_AUDIO, b, 1'b0, '0);
        return play;
      end
      PARSE_DROP: begin
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == 32'd0) end_payload();
        return 1'b0;
      end
      PARSE_PAD: begin
        pad_due = 1'b0;
        hdr_idx = 3'd0;
        parse   = PARSE_HDR;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  initial begin
    fail_count   = 0;
    results_due  = 0;
    beat_count   = 0;
    result_count = 0;
    frame_count  = 0;
    halt_count   = 0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      max_chunk  = MaxChunkReset;
      frame_cap  = CapacityReset;
      parse      = PARSE_HDR;
      hdr_idx    = 3'd0;
      id_bytes   = '0;
      chunk_len  = '0;
      bytes_left = '0;
      pad_due    = 1'b0;
      due_q.delete();
    end else begin
      // compare the output beat before this edge's input can add to the queue
      if (m_axis_tvalid && m_axis_tready) begin
        result_count = result_count + 1;
        if (m_axis_tlast) frame_count = frame_count + 1;
        if (due_q.size() == 0) begin
          $error("result beat with nothing expected: event %0d payload %0d",
                 m_axis_tuser, m_axis_tdata[7:0]);
          fail_count = fail_count + 1;
        end else begin
          want = due_q.pop_front();
          if (want.ev == EV_BAD) halt_count = halt_count + 1;
          if (m_axis_tuser != want.ev) begin
            $error("event_res: expected %0d, got %0d", want.ev, m_axis_tuser);
            fail_count = fail_count + 1;
          end
          if (m_axis_tdata[7:0] != want.payload) begin
            $error("payload: expected %0d, got %0d", want.payload, m_axis_tdata[7:0]);
            fail_count = fail_count + 1;
          end
          if (m_axis_tlast != want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, m_axis_tlast);
            fail_count = fail_count + 1;
          end
          if (m_axis_tdata[27:8] != want.frame_size) begin
            $error("frame_size: expected %0d, got %0d", want.frame_size,
                   m_axis_tdata[27:8]);
            fail_count = fail_count + 1;
          end
          if (m_axis_tdata[31:28] != 4'd0) begin
            $error("tdata fill: expected 0, got %0d", m_axis_tdata[31:28]);
            fail_count = fail_count + 1;
          end
        end
      end

      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_CHUNK: max_chunk = cfg_data_i[MaxChunkW-1:0];
          CFG_FRAME_CAP: frame_cap = cfg_data_i[FrameSizeW-1:0];
          default: ;
        endcase
      end

      // input beat
      if (s_axis_tvalid && s_axis_tready) begin
        beat_count = beat_count + 1;
        if (demux_step(s_axis_tdata[7:0], s_axis_tdata[8], s_axis_tdata[9], next_res))
          due_q.push_back(next_res);
      end
    end
    results_due = due_q.size();
  end

endmodule

// ===== dv/avi_chunk_demux_top_tb.sv =====
// Testbench top for the AVI chunk demultiplexer: stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps

module avi_chunk_demux_top_tb;
  import acd_pkg::*;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  cfg_idx_e            cfg_idx_i     = CFG_MAX_CHUNK;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [2:0]          m_axis_tuser;
  logic                m_axis_tlast;

  int fail_count;
  int results_due;
  int beat_count;
  int result_count;
  int frame_count;
  int halt_count;

  // pacing and register shadows
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned cur_max      = 32'(MaxChunkReset);
  int unsigned cur_cap      = 32'(CapacityReset);
  int          sent_beats   = 0;

  avi_chunk_demux_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  avi_chunk_demux_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .results_due   (results_due),
    .beat_count    (beat_count),
    .result_count  (result_count),
    .frame_count   (frame_count),
    .halt_count    (halt_count)
  );

  always #6 clk_i = ~clk_i;

  // receiver backpressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // run limit
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // one beat on the input stream; entered and left at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic skip, input logic play);
    logic taken;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, play, skip, b};
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = s_axis_tready;
    end
    sent_beats = sent_beats + 1;
    @(negedge clk_i);
  endtask

  // stop sending and let every expected result and the pipeline drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (results_due != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_MAX_CHUNK) cur_max = 32'(value);
    else cur_cap = 32'(value[FrameSizeW-1:0]);
    @(negedge clk_i);
  endtask

  // 8-byte chunk header: id bytes, then the size little-endian
  task automatic send_header(input logic [7:0] t2, input logic [7:0] t3,
                             input logic [31:0] size, input logic skip_last);
    logic [7:0] hb;
    for (int k = 0; k < 8; k++) begin
      case (k)
        2:       hb = t2;
        3:       hb = t3;
        4, 5, 6, 7: hb = size[8*(k-4) +: 8];
        default: hb = 8'($urandom_range(0, 255));
      endcase
      push_byte(hb, (k == 7) ? skip_last : 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end
  endtask

  task automatic send_chunk(input logic [7:0] t2, input logic [7:0] t3,
                            input int unsigned size, input logic skip_last);
    send_header(t2, t3, size, skip_last);
    for (int unsigned n = 0; n < size; n++)
      push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                ($urandom_range(0, 3) != 0));
    if (size[0])
      push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
  endtask

  // mostly short chunks, with the capacity edge hit now and then
  function automatic int unsigned pick_size();
    int unsigned s;
    case ($urandom_range(0, 7))
      0:       s = cur_cap;
      1:       s = cur_cap + 1;
      default: s = $urandom_range(0, 20);
    endcase
    if (s > 64) s = $urandom_range(0, 64);
    if (s > cur_max) s = cur_max;
    return s;
  endfunction

  // random chunk stream: mostly video and audio, some near-miss and junk ids
  task automatic run_chunks(input int n_beats);
    int          start;
    int unsigned pick;
    start = sent_beats;
    while (sent_beats - start < n_beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        send_chunk(ChD, ChC, pick_size(), ($urandom_range(0, 4) == 0));
      else if (pick < 75)
        send_chunk(ChW, ChB, pick_size(), 1'($urandom_range(0, 1)));
      else if (pick < 85)
        case ($urandom_range(0, 2))
          0:       send_chunk(ChD, ChB, pick_size(), 1'b1);
          1:       send_chunk(ChW, ChC, pick_size(), 1'b0);
          default: send_chunk(ChC, ChD, pick_size(), 1'b1);
        endcase
      else
        send_chunk(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pick_size(),
                   1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: short frame with pad, empty frame, skip over an oversize frame
    snd_idle_pct = 20;
    rcv_idle_pct = 72;
    cfg_write(CFG_FRAME_CAP, 24'd3);
    send_header(ChD, ChC, 32'd1, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b1);
    push_byte(8'h00, 1'b0, 1'b0);
    send_chunk(ChD, ChC, 0, 1'b0);
    send_chunk(ChD, ChC, 4, 1'b1);
    settle();

    cfg_write(CFG_FRAME_CAP, 24'($urandom_range(4, 24)));
    run_chunks(400);
    settle();

    // widest registers, sender slow and receiver fast
    snd_idle_pct = 72;
    rcv_idle_pct = 20;
    cfg_write(CFG_MAX_CHUNK, 24'hFF_FFFF);
    cfg_write(CFG_FRAME_CAP, 24'h0F_FFFF);
    run_chunks(350);
    settle();

    // zero capacity, tight size limit, full rate
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    cfg_write(CFG_MAX_CHUNK, 24'($urandom_range(8, 40)));
    cfg_write(CFG_FRAME_CAP, 24'd0);
    run_chunks(300);
    settle();

    cfg_write(CFG_MAX_CHUNK, 24'($urandom_range(16, 200)));
    cfg_write(CFG_FRAME_CAP, 24'($urandom_range(1, 30)));
    run_chunks(300);
    settle();

    // size limit of zero: empty chunk passes, any nonzero size halts for good
    cfg_write(CFG_MAX_CHUNK, 24'd0);
    send_chunk(ChW, ChB, 0, 1'b0);
    send_header(ChD, ChC, 32'($urandom) | 32'd1, 1'b0);
    send_header(ChD, ChC, 32'd0, 1'b0);
    repeat (12)
      push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    settle();
    repeat (8) @(negedge clk_i);

    $display("Sent %0d stream beats over six register settings and three pacing modes,",
             beat_count);
    $display("checked %0d result beats: %0d frame ends, %0d halt events.",
             result_count, frame_count, halt_count);
    if (fail_count == 0 && results_due == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/acd_pkg.sv
sv/acd_parser.sv
sv/acd_out_buf.sv
sv/avi_chunk_demux_top.sv
dv/avi_chunk_demux_checker.sv
dv/avi_chunk_demux_top_tb.sv
